/* rtl/core/dht_pkg.sv */
// Shared types and constants for the diffraction hyperbola traveltime block.
// Holds field widths, configuration register codes and the beat structs.
// No dependencies.
`default_nettype none

package dht_pkg;

    localparam int APEX_W     = 16;  // Q12.4 apex trace and apex time
    localparam int SLOPE_W    = 16;  // Q4.12 slope scale
    localparam int APER_W     = 6;   // half aperture register
    localparam int SECT_W     = 13;  // section size registers
    localparam int TRACE_W    = 14;  // signed trace number
    localparam int TIME_W     = 13;  // traveltime sample index
    localparam int COUNT_W    = 7;   // results per pick, up to twice the half aperture
    localparam int OFFS_W     = 10;  // absolute Q.4 offset, at most 32*16+8
    localparam int MOFF_W     = OFFS_W + SLOPE_W;
    localparam int MSQ_W      = 2 * MOFF_W;
    localparam int T0SQ_W     = 2 * APEX_W;
    localparam int T0SH       = 24;  // t0 squared is scaled by 2^24 to reach Q.32
    localparam int SUM_W      = T0SQ_W + T0SH + 1;
    localparam int RSH        = 30;  // rounding boundary sits on multiples of 2^30
    localparam int ROOT_W     = 14;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOPE_SCALE     = 4'd0,
        CFG_APERTURE_TRACES = 4'd1,
        CFG_SECTION_TRACES  = 4'd2,
        CFG_SECTION_SAMPLES = 4'd3
    } cfg_index_t;

    typedef struct packed {
        logic [APEX_W-1:0] apex_trace;
        logic [APEX_W-1:0] apex_time;
    } in_item_t;

    typedef struct packed {
        logic signed [TRACE_W-1:0] trace_index;
        logic [TIME_W-1:0]         time_index;
        logic                      inside_res;
        logic                      last;
    } out_item_t;

    // Configuration after saturation to the block limits.
    typedef struct packed {
        logic [SLOPE_W-1:0] slope_scale;
        logic [APER_W-1:0]  half;
        logic [SECT_W-1:0]  ntr;
        logic [SECT_W-1:0]  nsa;
    } cfg_t;

    // One accepted pick, ready for the trace walker.
    typedef struct packed {
        logic signed [TRACE_W-1:0] start_trace;
        logic [COUNT_W-1:0]        count;
        logic [APEX_W-1:0]         apex_trace;
        logic [T0SQ_W-1:0]         t0sq;
    } job_t;

    // Sideband that travels with each trace through the arithmetic pipeline.
    typedef struct packed {
        logic signed [TRACE_W-1:0] trace_index;
        logic                      last;
    } tag_t;

endpackage

`default_nettype wire

/* rtl/core/dht_front.sv */
// Front end: accepts picks, rounds the apex to a centre trace and builds a job.
// Picks with a zero aperture are taken and dropped here. Depends on dht_pkg.
`default_nettype none

module dht_front
    import dht_pkg::*;
(
    input  wire logic     in_valid,
    input  wire in_item_t in_item,
    output logic          in_ready,
    input  wire cfg_t     cfg,
    input  wire logic     queue_full,
    output logic          push,
    output job_t          job
);

    logic [APEX_W:0]   centre_sum;
    logic [SECT_W-1:0] centre;

    assign centre_sum = {1'b0, in_item.apex_trace} + (APEX_W+1)'(8);
    assign centre     = centre_sum[APEX_W:4];

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full && (cfg.half != '0);

    always_comb
    begin
        job.start_trace = TRACE_W'(centre) - TRACE_W'(cfg.half);
        job.count       = {cfg.half, 1'b0};
        job.apex_trace  = in_item.apex_trace;
        job.t0sq        = T0SQ_W'(in_item.apex_time) * T0SQ_W'(in_item.apex_time);
    end

endmodule

`default_nettype wire

/* rtl/core/dht_queue.sv */
// Short job queue between the front end and the trace walker.
// Two entries of job_t, first in first out. Depends on dht_pkg.
`default_nettype none

module dht_queue
    import dht_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      job_valid,
    output job_t      head_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full      = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign job_valid = (fill_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && job_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dht_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Carries a tag_t sideband alongside each radicand. Depends on dht_pkg.
`default_nettype none

module dht_sqrt
    import dht_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [RAD_W-1:0] rad,
    input  wire tag_t             in_tag,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     root,
    output tag_t                  out_tag
);

    logic              vld_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    tag_t              tag_reg  [ROOT_W];

    logic              vld_in  [ROOT_W];
    logic [REM_W-1:0]  rem_in  [ROOT_W];
    logic [ROOT_W-1:0] root_in [ROOT_W];
    logic [RAD_W-1:0]  rad_in  [ROOT_W];
    tag_t              tag_in  [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic [REM_W-1:0] rem_x;
            logic [REM_W-1:0] trial;
            logic             fits;

            if (k == 0)
            begin : g_first
                assign vld_in[k]  = in_valid;
                assign rem_in[k]  = '0;
                assign root_in[k] = '0;
                assign rad_in[k]  = rad;
                assign tag_in[k]  = in_tag;
            end
            else
            begin : g_rest
                assign vld_in[k]  = vld_reg[k-1];
                assign rem_in[k]  = rem_reg[k-1];
                assign root_in[k] = root_reg[k-1];
                assign rad_in[k]  = rad_reg[k-1];
                assign tag_in[k]  = tag_reg[k-1];
            end

            // Bring down the next two radicand bits and try the next root bit.
            assign rem_x = {rem_in[k][REM_W-3:0], rad_in[k][RAD_W-1 -: 2]};
            assign trial = {1'b0, root_in[k], 2'b01};
            assign fits  = (rem_x >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= fits ? rem_x - trial : rem_x;
                    root_reg[k] <= {root_in[k][ROOT_W-2:0], fits};
                    rad_reg[k]  <= {rad_in[k][RAD_W-3:0], 2'b00};
                    tag_reg[k]  <= tag_in[k];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/core/dht_back.sv */
// Back end: walks the traces of one job, squares the offsets and times,
// takes the rounded root and registers each result beat. Depends on dht_pkg, dht_sqrt.
`default_nettype none

module dht_back
    import dht_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic job_valid,
    input  wire job_t head_job,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_item
);

    logic adv;
    logic issue;

    // Trace walker.
    logic                      busy_reg;
    logic signed [TRACE_W-1:0] cur_trace_reg;
    logic [COUNT_W-1:0]        left_reg;
    logic [APEX_W-1:0]         apex_trace_reg;
    logic [T0SQ_W-1:0]         t0sq_reg;

    // Offset stage.
    logic signed [TRACE_W+4:0] offs;
    logic [TRACE_W+4:0]        offs_mag;
    logic                      a_vld_reg;
    tag_t                      a_tag_reg;
    logic [OFFS_W-1:0]         a_mabs_reg;
    logic [T0SQ_W-1:0]         a_t0sq_reg;

    // Product stages.
    logic                      b_vld_reg;
    tag_t                      b_tag_reg;
    logic [MOFF_W-1:0]         b_moff_reg;
    logic [T0SQ_W-1:0]         b_t0sq_reg;
    logic                      c_vld_reg;
    tag_t                      c_tag_reg;
    logic [MSQ_W-1:0]          c_msq_reg;
    logic [T0SQ_W-1:0]         c_t0sq_reg;
    logic [SUM_W-1:0]          sum;
    logic                      d_vld_reg;
    tag_t                      d_tag_reg;
    logic [RAD_W-1:0]          d_rad_reg;

    // Root and output.
    logic                      r_vld;
    logic [ROOT_W-1:0]         r_root;
    tag_t                      r_tag;
    logic [ROOT_W:0]           root_up;
    logic [ROOT_W-1:0]         t_round;
    logic [TIME_W-1:0]         t_sat;
    logic                      in_sec;
    out_item_t                 out_next;
    logic                      out_valid_reg;
    out_item_t                 out_item_reg;

    // The whole pipeline moves whenever the output register can take a beat.
    assign adv   = !out_valid_reg || out_ready;
    assign pop   = !busy_reg && job_valid;
    assign issue = busy_reg && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
        end
        else if (issue && (left_reg == COUNT_W'(1)))
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_trace_reg  <= head_job.start_trace;
            left_reg       <= head_job.count;
            apex_trace_reg <= head_job.apex_trace;
            t0sq_reg       <= head_job.t0sq;
        end
        else if (issue)
        begin
            cur_trace_reg <= cur_trace_reg + TRACE_W'(1);
            left_reg      <= left_reg - COUNT_W'(1);
        end
    end

    // Q.4 offset of the current trace from the apex.
    assign offs     = {cur_trace_reg[TRACE_W-1], cur_trace_reg, 4'b0000}
                      - $signed({3'b000, apex_trace_reg});
    assign offs_mag = offs[TRACE_W+4] ? -offs : offs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            d_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg     <= issue;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            d_vld_reg     <= c_vld_reg;
            out_valid_reg <= r_vld;
        end
    end

    // t0^2 * 2^24 + (offset * slope)^2 is Q.32; rounding needs only its bits above 2^30.
    assign sum = (SUM_W'(c_t0sq_reg) << T0SH) + SUM_W'(c_msq_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_tag_reg.trace_index <= cur_trace_reg;
            a_tag_reg.last        <= (left_reg == COUNT_W'(1));
            a_mabs_reg            <= offs_mag[OFFS_W-1:0];
            a_t0sq_reg            <= t0sq_reg;

            b_tag_reg  <= a_tag_reg;
            b_moff_reg <= MOFF_W'(a_mabs_reg) * MOFF_W'(cfg.slope_scale);
            b_t0sq_reg <= a_t0sq_reg;

            c_tag_reg  <= b_tag_reg;
            c_msq_reg  <= MSQ_W'(b_moff_reg) * MSQ_W'(b_moff_reg);
            c_t0sq_reg <= b_t0sq_reg;

            d_tag_reg <= c_tag_reg;
            d_rad_reg <= RAD_W'(sum[SUM_W-1:RSH]);

            out_item_reg <= out_next;
        end
    end

    dht_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_vld_reg),
        .rad       (d_rad_reg),
        .in_tag    (d_tag_reg),
        .out_valid (r_vld),
        .root      (r_root),
        .out_tag   (r_tag)
    );

    // Traveltime k is reached once the scaled sum reaches (2k-1)^2, so the
    // rounded time is half of the root plus one.
    assign root_up = {1'b0, r_root} + (ROOT_W+1)'(1);
    assign t_round = root_up[ROOT_W:1];
    assign t_sat   = t_round[ROOT_W-1] ? '1 : t_round[TIME_W-1:0];
    assign in_sec  = !r_tag.trace_index[TRACE_W-1]
                     && (r_tag.trace_index[SECT_W-1:0] < cfg.ntr)
                     && (t_sat < cfg.nsa);

    always_comb
    begin
        out_next.trace_index = r_tag.trace_index;
        out_next.time_index  = t_sat;
        out_next.inside_res  = in_sec;
        out_next.last        = r_tag.last;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

/* rtl/core/diffraction_hyperbola_traveltime_top.sv */
// Top level of the diffraction hyperbola traveltime generator.
// Holds the configuration registers and joins front end, job queue and back end.
// Depends on dht_pkg, dht_front, dht_queue, dht_back.
`default_nettype none

// Each input beat is one picked diffraction apex (Q12.4 trace position and
// Q12.4 time). The apex is rounded to a centre trace c and the block emits one
// output beat for every trace from c minus the half aperture up to, but not
// including, c plus the half aperture, in increasing order, carrying the trace
// number, the rounded traveltime sqrt(t0^2 + (offset*slope)^2), an inside flag
// and a last flag on the final beat. A pick taken while the half aperture is
// zero produces no beats. The front end places each accepted pick in a
// two-entry queue, so up to two picks can wait while the back end works.
// The back end loads a new pick only when idle and then issues one trace per
// cycle while the output is not stalled; this trace walker sets the sustained
// rate. Each trace passes four offset and product stages, a fourteen-stage
// square root and an output register. A stall on the output side freezes the
// whole pipeline without losing beats. The configuration port is always
// ready; registers are to be written only while no pick is in flight.

module diffraction_hyperbola_traveltime_top
    import dht_pkg::*;
#(
    parameter int MAX_HALF_APERTURE = 32,
    parameter int MAX_TRACES        = 4096,
    parameter int MAX_SAMPLES       = 4096
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_item,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers, reset to their documented defaults.
    logic [SLOPE_W-1:0] slope_scale_reg;
    logic [APER_W-1:0]  aperture_traces_reg;
    logic [SECT_W-1:0]  section_traces_reg;
    logic [SECT_W-1:0]  section_samples_reg;
    cfg_t               cfg;

    logic push;
    job_t push_job;
    logic queue_full;
    logic pop;
    logic job_valid;
    job_t head_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_scale_reg     <= SLOPE_W'(4096);
            aperture_traces_reg <= APER_W'(16);
            section_traces_reg  <= SECT_W'(4096);
            section_samples_reg <= SECT_W'(4096);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SLOPE_SCALE:     slope_scale_reg     <= cfg_data[SLOPE_W-1:0];
                CFG_APERTURE_TRACES: aperture_traces_reg <= cfg_data[APER_W-1:0];
                CFG_SECTION_TRACES:  section_traces_reg  <= cfg_data[SECT_W-1:0];
                CFG_SECTION_SAMPLES: section_samples_reg <= cfg_data[SECT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Register values above the block limits are clamped to those limits.
    always_comb
    begin
        cfg.slope_scale = slope_scale_reg;
        cfg.half = (32'(aperture_traces_reg) > MAX_HALF_APERTURE)
                   ? APER_W'(MAX_HALF_APERTURE) : aperture_traces_reg;
        cfg.ntr  = (32'(section_traces_reg) > MAX_TRACES)
                   ? SECT_W'(MAX_TRACES) : section_traces_reg;
        cfg.nsa  = (32'(section_samples_reg) > MAX_SAMPLES)
                   ? SECT_W'(MAX_SAMPLES) : section_samples_reg;
    end

    dht_front u_front
    (
        .in_valid   (in_valid),
        .in_item    (in_item),
        .in_ready   (in_ready),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    dht_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .job_valid (job_valid),
        .head_job  (head_job)
    );

    dht_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
